### rtl/rle_sprite_row_decoder_core_assert.svh
// Assertion macros shared by the RLE sprite row decoder modules.
// Expects signals clk and rst_n in the including module; no other dependencies.
`ifndef RLE_SPRITE_ROW_DECODER_CORE_ASSERT_SVH
`define RLE_SPRITE_ROW_DECODER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define RSRD_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("rsrd assertion failed");
`define RSRD_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("rsrd assertion failed");
`else
`define RSRD_ASSERT_IMP(lbl, pre, post)
`define RSRD_ASSERT_NXT(lbl, pre, post)
`endif
`endif

### rtl/rsrd_pkg.sv
// Package for the RLE sprite row decoder: phases, result kinds, queue entry type.
// No dependencies.
`timescale 1ns / 1ps
package rsrd_pkg;

  localparam int RSRD_MAX_ROWS  = 1024;
  localparam int RSRD_MAX_PITCH = 4096;

  localparam int HEIGHT_W = 11;
  localparam int PITCH_W  = 13;
  localparam int CFG_W    = 13;
  localparam int BASE_W   = 22;
  localparam int OUT_DW   = 80;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam logic [0:0] REG_HEIGHT = 1'b0;
  localparam logic [0:0] REG_PITCH  = 1'b1;

  localparam logic [15:0] TOK_FILL  = 16'h00C0;
  localparam logic [15:0] TOK_LIT1  = 16'h00C1;
  localparam logic [15:0] TOK_LIT2  = 16'h00C2;
  localparam logic [15:0] TOK_LIT3  = 16'h00C3;

  typedef enum logic [2:0] {
    PH_LEN,
    PH_TOKEN,
    PH_FILL_CNT,
    PH_LIT_CNT,
    PH_LITERAL,
    PH_END_PEND,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    K_LIT  = 2'd0,
    K_FILL = 2'd1,
    K_END  = 2'd2,
    K_ERR  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [9:0]  row;
    logic [15:0] col;
    logic [21:0] base;
    logic [15:0] pixel;
    logic [15:0] run;
  } q_entry_t;

endpackage

### rtl/rle_sprite_row_decoder_core.sv
// Top level of the RLE sprite row decoder: front decode, result queue, output stage.
// Depends on rsrd_pkg, rsrd_front, rsrd_queue and rsrd_back.
//
// Usage:
//   Input stream: one 16-bit coded word per transaction on in_tdata; in_tuser
//   high marks the first word of an image and restarts decoding with it as
//   the length word of row 0.
//   Output stream: at most one write per input word. out_tuser carries the
//   kind (literal, fill, image end, error); out_tdata carries row, column,
//   address (row base plus column), pixel and run length.
//   Config: cfg_we with cfg_index 0 writes image_height, index 1 dest_pitch.
//   Write only while the block is drained.
// Throughput: one word per cycle while the queue is not full; every word updates
//   the decode state of the front state machine.
// Path: the record of a taken word enters the queue at the edge that takes the
//   word and then moves on into the output register, which drives out_tvalid.
// Reset: rst_n (synchronous) sets height 1, pitch 256 and waits for a length
//   word of row 0; queue and output stage come up empty.
// Stall: while out_tready is low, results gather in the four-entry queue;
//   in_tready drops only once the queue is full.
`timescale 1ns / 1ps
module rle_sprite_row_decoder_core
  import rsrd_pkg::*;
#(
  parameter int MAX_ROWS  = RSRD_MAX_ROWS,
  parameter int MAX_PITCH = RSRD_MAX_PITCH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [15:0]       in_tdata,   // [15:0] src_word
  input  logic              in_tuser,   // [0] start_of_image
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // [9:0] row, [21:10] column, [43:22] address,
                                        // [59:44] pixel, [75:60] run_length, [79:76] zero
  output logic [1:0]        out_tuser   // [1:0] kind
);

  logic     q_full, push, pop, head_valid;
  q_entry_t push_entry, head;

  // Front: takes each word while the queue has room, keeps the row/column/run counters, emits records.
  rsrd_front #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_PITCH (MAX_PITCH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_word    (in_tdata),
    .in_sof     (in_tuser),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // Queue decouples decode from downstream backpressure.
  rsrd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Back: address add and output register.
  rsrd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

### rtl/rsrd_front.sv
// Front end: config registers and the per-word decode state machine.
// Depends on rsrd_pkg and rle_sprite_row_decoder_core_assert.svh.
`timescale 1ns / 1ps
`include "rle_sprite_row_decoder_core_assert.svh"
module rsrd_front
  import rsrd_pkg::*;
#(
  parameter int MAX_ROWS  = RSRD_MAX_ROWS,
  parameter int MAX_PITCH = RSRD_MAX_PITCH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [15:0]      in_word,
  input  logic             in_sof,
  input  logic             q_full,
  output logic             push,
  output q_entry_t         push_entry
);

  localparam int RC_W = $clog2(MAX_ROWS + 1);

  logic [HEIGHT_W-1:0] height_r;
  logic [PITCH_W-1:0]  pitch_r;

  phase_t              phase_r, phase_nxt;
  logic [RC_W-1:0]     row_r, row_nxt;
  logic [15:0]         left_r, left_nxt;
  logic [15:0]         col_r, col_nxt;
  logic [15:0]         lit_r, lit_nxt;
  logic [BASE_W-1:0]   base_r, base_nxt;

  phase_t              c_phase;
  logic [RC_W-1:0]     c_row, er_row, eff_h;
  logic [15:0]         c_left, c_col, c_lit, lit_dec, col_inc;
  logic [BASE_W-1:0]   c_base, er_base;
  logic [PITCH_W-1:0]  eff_p;
  logic [16:0]         col_sum;
  logic [15:0]         col_sat;
  logic                acc, er_done, left_le1, fill_over, lit_over, res_valid;
  q_entry_t            res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r <= HEIGHT_W'(1);
      pitch_r  <= PITCH_W'(256);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEIGHT: height_r <= cfg_wdata[HEIGHT_W-1:0];
        REG_PITCH:  pitch_r  <= cfg_wdata[PITCH_W-1:0];
        default: ;
      endcase
    end
  end

  // register value clamping
  always_comb begin
    if (height_r == '0) eff_h = RC_W'(1);
    else if (height_r > MAX_ROWS) eff_h = RC_W'(MAX_ROWS);
    else eff_h = RC_W'(height_r);
    if (pitch_r > MAX_PITCH) eff_p = PITCH_W'(MAX_PITCH);
    else eff_p = pitch_r;
  end

  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;

  // start of image clears the decoder before this word is taken
  assign c_phase = in_sof ? PH_LEN : phase_r;
  assign c_row   = in_sof ? '0 : row_r;
  assign c_left  = in_sof ? '0 : left_r;
  assign c_col   = in_sof ? '0 : col_r;
  assign c_lit   = in_sof ? '0 : lit_r;
  assign c_base  = in_sof ? '0 : base_r;

  assign er_row    = c_row + RC_W'(1);
  assign er_base   = c_base + BASE_W'(eff_p);
  assign er_done   = er_row >= eff_h;
  assign left_le1  = c_left <= 16'd1;
  assign col_sum   = {1'b0, c_col} + {1'b0, in_word};
  assign col_sat   = col_sum[16] ? 16'hFFFF : col_sum[15:0];
  assign col_inc   = (c_col == 16'hFFFF) ? 16'hFFFF : c_col + 16'd1;
  assign fill_over = col_sum > 17'(eff_p);
  assign lit_over  = c_col >= 16'(eff_p);
  assign lit_dec   = c_lit - 16'd1;

  // next phase
  always_comb begin
    phase_nxt = c_phase;
    case (c_phase)
      PH_LEN: begin
        if (in_word == '0) phase_nxt = er_done ? PH_DONE : PH_LEN;
        else phase_nxt = PH_TOKEN;
      end
      PH_TOKEN: begin
        if (left_le1) phase_nxt = er_done ? PH_DONE : PH_LEN;
        else if (in_word == TOK_FILL) phase_nxt = PH_FILL_CNT;
        else if (in_word inside {TOK_LIT1, TOK_LIT2, TOK_LIT3})
          phase_nxt = PH_LIT_CNT;
      end
      PH_FILL_CNT: begin
        if (left_le1) phase_nxt = er_done ? PH_END_PEND : PH_LEN;
        else phase_nxt = PH_TOKEN;
      end
      PH_LIT_CNT: begin
        if (left_le1) phase_nxt = er_done ? PH_END_PEND : PH_LEN;
        else phase_nxt = (in_word != '0) ? PH_LITERAL : PH_TOKEN;
      end
      PH_LITERAL: begin
        if (left_le1) phase_nxt = er_done ? PH_END_PEND : PH_LEN;
        else if (lit_dec == '0) phase_nxt = PH_TOKEN;
      end
      PH_END_PEND: phase_nxt = PH_DONE;
      default:     phase_nxt = PH_DONE;
    endcase
  end

  // counters and result
  always_comb begin
    row_nxt   = c_row;
    left_nxt  = c_left;
    col_nxt   = c_col;
    lit_nxt   = c_lit;
    base_nxt  = c_base;
    res_valid = 1'b0;
    res.kind  = K_ERR;
    res.row   = 10'(c_row);
    res.col   = c_col;
    res.base  = c_base;
    res.pixel = '0;
    res.run   = '0;
    case (c_phase)
      PH_LEN: begin
        left_nxt = in_word;
        col_nxt  = '0;
        if (in_word == '0) begin
          left_nxt = '0;
          lit_nxt  = '0;
          row_nxt  = er_row;
          base_nxt = er_base;
          res_valid = er_done;
          res = '{kind: K_END, default: '0};
        end
      end
      PH_TOKEN: begin
        if (left_le1) begin
          left_nxt = '0;
          lit_nxt  = '0;
          col_nxt  = '0;
          row_nxt  = er_row;
          base_nxt = er_base;
          res_valid = er_done;
          res = '{kind: K_END, default: '0};
        end else begin
          left_nxt = c_left - 16'd1;
        end
      end
      PH_FILL_CNT, PH_LIT_CNT, PH_LITERAL: begin
        if (left_le1) begin
          // run reaches the row's trailing word: error, row closes
          res_valid = 1'b1;
          left_nxt = '0;
          lit_nxt  = '0;
          col_nxt  = '0;
          row_nxt  = er_row;
          base_nxt = er_base;
        end else begin
          left_nxt = c_left - 16'd1;
          if (c_phase == PH_FILL_CNT) begin
            res_valid = 1'b1;
            res.kind  = fill_over ? K_ERR : K_FILL;
            res.run   = in_word;
            col_nxt   = col_sat;
          end else if (c_phase == PH_LIT_CNT) begin
            lit_nxt = in_word;
          end else begin
            res_valid = 1'b1;
            res.kind  = lit_over ? K_ERR : K_LIT;
            res.pixel = lit_over ? 16'd0 : in_word;
            res.run   = 16'd1;
            col_nxt   = col_inc;
            lit_nxt   = lit_dec;
          end
        end
      end
      PH_END_PEND: begin
        res_valid = 1'b1;
        res = '{kind: K_END, default: '0};
      end
      default: ;
    endcase
  end

  assign push       = acc && res_valid;
  assign push_entry = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEN;
      row_r   <= '0;
      left_r  <= '0;
      col_r   <= '0;
      lit_r   <= '0;
      base_r  <= '0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      row_r   <= row_nxt;
      left_r  <= left_nxt;
      col_r   <= col_nxt;
      lit_r   <= lit_nxt;
      base_r  <= base_nxt;
    end
  end

  `RSRD_ASSERT_NXT(a_end_goes_done, push && push_entry.kind == K_END, phase_r == PH_DONE)
  `RSRD_ASSERT_IMP(a_done_silent, phase_r == PH_DONE && acc && !in_sof, !push)
  `RSRD_ASSERT_IMP(a_row_bound, 1'b1, row_r <= RC_W'(MAX_ROWS))

endmodule

### rtl/rsrd_queue.sv
// Short result queue between the decode front end and the output stage.
// Depends on rsrd_pkg and rle_sprite_row_decoder_core_assert.svh.
`timescale 1ns / 1ps
`include "rle_sprite_row_decoder_core_assert.svh"
module rsrd_queue
  import rsrd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_entry,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output q_entry_t head
);

  q_entry_t          mem_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_CW-1:0]   cnt_r;

  assign full       = cnt_r == Q_CW'(Q_DEPTH);
  assign head_valid = cnt_r != '0;
  assign head       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      if (push && !pop) cnt_r <= cnt_r + Q_CW'(1);
      else if (pop && !push) cnt_r <= cnt_r - Q_CW'(1);
    end
  end

  `RSRD_ASSERT_IMP(a_cnt_range, 1'b1, cnt_r <= Q_CW'(Q_DEPTH))
  `RSRD_ASSERT_IMP(a_no_push_full, push, !full)
  `RSRD_ASSERT_IMP(a_no_pop_empty, pop, head_valid)

endmodule

### rtl/rsrd_back.sv
// Back end: address add and the registered output stage of the result stream.
// Depends on rsrd_pkg.
`timescale 1ns / 1ps
module rsrd_back
  import rsrd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  q_entry_t          head,
  output logic              pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,
  output logic [1:0]        out_tuser
);

  logic              valid_r;
  logic [OUT_DW-1:0] data_r, data_nxt;
  logic [1:0]        kind_r;
  logic [21:0]       addr;

  assign pop  = head_valid && (!valid_r || out_tready);
  assign addr = head.base + 22'(head.col);
  assign data_nxt = {4'd0, head.run, head.pixel, addr, head.col[11:0], head.row};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      data_r <= data_nxt;
      kind_r <= head.kind;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = kind_r;

endmodule
